// ----- design/der_pkg.sv -----
// Shared types, codes and constants of the debounced event recorder.
package der_pkg;

    // Default sizes
    localparam int ONESHOT_EVENTS_DEF = 8;
    localparam int LEVEL_EVENTS_DEF   = 4;
    localparam int HISTORY_DEPTH_DEF  = 10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int HOLD_REGS = 4;
    localparam logic [7:0] HOLD_RESET = 8'd3;

    localparam logic [1:0] REG_HOLD_A = 2'd0;
    localparam logic [1:0] REG_HOLD_B = 2'd1;
    localparam logic [1:0] REG_HOLD_C = 2'd2;
    localparam logic [1:0] REG_HOLD_D = 2'd3;

    // Opcodes
    localparam logic [1:0] OP_TRIGGER = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Saturation limits
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0]  CONFIRM_MAX = 8'hFF;

    // Work class of an item, decided by the front
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_TRIGGER,
        KIND_SAMPLE,
        KIND_READ_LEVEL,
        KIND_READ_ONESHOT
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  ev;
        logic        act;
        logic [31:0] now;
        logic        nv;
        logic [3:0]  slot;
        logic        slot_ok;
    } item_t;

    typedef struct packed {
        logic        started;
        logic        ended;
        logic [15:0] event_total;
        logic [31:0] accum_seconds;
        logic [31:0] start_stamp;
        logic [31:0] end_stamp;
        logic        event_open;
    } result_t;

    typedef logic [HOLD_REGS-1:0][7:0] hold_set_t;

endpackage

// ----- design/der_front.sv -----
// Front part: accepts input items and classifies them for the back part.
module der_front #(
    parameter int ONESHOT_EVENTS = der_pkg::ONESHOT_EVENTS_DEF,
    parameter int LEVEL_EVENTS   = der_pkg::LEVEL_EVENTS_DEF,
    parameter int HISTORY_DEPTH  = der_pkg::HISTORY_DEPTH_DEF
) (
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     opcode,
    input  logic [2:0]     event_index,
    input  logic           level_active,
    input  logic [31:0]    now_seconds,
    input  logic           now_valid,
    input  logic [3:0]     history_slot,
    input  logic           q_full,
    output logic           q_push,
    output der_pkg::item_t q_item
);
    import der_pkg::*;

    logic os_ok;
    logic lv_ok;

    assign os_ok = (32'(event_index) < ONESHOT_EVENTS);
    assign lv_ok = (32'(event_index) < LEVEL_EVENTS);

    // Hold the input while the queue is full
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the item
    always_comb
    begin
        q_item         = '0;
        q_item.ev      = event_index;
        q_item.act     = level_active;
        q_item.now     = now_seconds;
        q_item.nv      = now_valid;
        q_item.slot    = history_slot;
        q_item.slot_ok = (32'(history_slot) < HISTORY_DEPTH);
        q_item.kind    = KIND_NONE;
        case (opcode)
            OP_TRIGGER:
            begin
                if (os_ok)
                    q_item.kind = KIND_TRIGGER;
            end
            OP_SAMPLE:
            begin
                if (lv_ok)
                    q_item.kind = KIND_SAMPLE;
            end
            OP_READ:
            begin
                if (level_active && lv_ok)
                    q_item.kind = KIND_READ_LEVEL;
                else if (!level_active && os_ok)
                    q_item.kind = KIND_READ_ONESHOT;
            end
            default:
            begin
                q_item.kind = KIND_NONE;
            end
        endcase
    end

endmodule

// ----- design/der_queue.sv -----
// Short item queue between the front and back parts.
module der_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  der_pkg::item_t push_item,
    input  logic           pop,
    output der_pkg::item_t pop_item,
    output logic           empty,
    output logic           full
);
    import der_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t          store_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCW'(QUEUE_DEPTH));
    assign pop_item = store_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- design/der_back.sv -----
// Back part: event state, history memories and the result register.
module der_back #(
    parameter int ONESHOT_EVENTS = der_pkg::ONESHOT_EVENTS_DEF,
    parameter int LEVEL_EVENTS   = der_pkg::LEVEL_EVENTS_DEF,
    parameter int HISTORY_DEPTH  = der_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  der_pkg::hold_set_t hold,
    input  logic               q_empty,
    input  der_pkg::item_t     q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output der_pkg::result_t   out_res
);
    import der_pkg::*;

    localparam int HW     = $clog2(HISTORY_DEPTH);
    localparam int OS_IW  = (ONESHOT_EVENTS > 1) ? $clog2(ONESHOT_EVENTS) : 1;
    localparam int LV_IW  = (LEVEL_EVENTS > 1) ? $clog2(LEVEL_EVENTS) : 1;
    localparam int OS_DEPTH = ONESHOT_EVENTS * HISTORY_DEPTH;
    localparam int LV_DEPTH = LEVEL_EVENTS * HISTORY_DEPTH;
    localparam int OS_AW  = $clog2(OS_DEPTH);
    localparam int LV_AW  = $clog2(LV_DEPTH);

    // Sequencer
    back_state_t state_reg;
    back_state_t state_next;
    item_t       item_reg;
    logic [HW-1:0] head_cap_reg;
    logic        commit;

    // Per-event state
    logic [15:0]   os_total_reg   [ONESHOT_EVENTS];
    logic [HW-1:0] os_head_reg    [ONESHOT_EVENTS];
    logic [15:0]   lv_total_reg   [LEVEL_EVENTS];
    logic [31:0]   lv_accum_reg   [LEVEL_EVENTS];
    logic [HW-1:0] lv_head_reg    [LEVEL_EVENTS];
    logic          open_reg       [LEVEL_EVENTS];
    logic [7:0]    confirm_reg    [LEVEL_EVENTS];
    logic [7:0]    release_reg    [LEVEL_EVENTS];

    // History memories with per-entry valid bits
    logic [31:0] os_mem       [OS_DEPTH];
    logic [32:0] lv_start_mem [LV_DEPTH];
    logic [32:0] lv_end_mem   [LV_DEPTH];
    logic [OS_DEPTH-1:0] os_valid_reg;
    logic [LV_DEPTH-1:0] lv_valid_reg;
    logic [31:0] os_rdata_reg;
    logic [32:0] lv_start_rdata_reg;
    logic [32:0] lv_end_rdata_reg;
    logic        os_rvalid_reg;
    logic        lv_rvalid_reg;

    // Read side
    logic [OS_IW-1:0] q_oi;
    logic [LV_IW-1:0] q_li;
    logic [HW-1:0]    r_head;
    logic [HW-1:0]    r_slot;
    logic [HW:0]      r_sum;
    logic [HW-1:0]    r_pos;
    logic [OS_AW-1:0] os_raddr;
    logic [LV_AW-1:0] lv_raddr;

    // Execute side
    logic [OS_IW-1:0] oi;
    logic [LV_IW-1:0] li;
    logic [7:0]       hc;
    logic [7:0]       cc;
    logic [7:0]       rc;
    logic [HW-1:0]    next_pos;
    logic [32:0]      start_s;
    logic [32:0]      end_s;
    logic [32:0]      diff;
    logic [31:0]      dur;
    logic [32:0]      acc_sum;
    logic [8:0]       conf_sum;
    logic [15:0]      n_os_total;
    logic [HW-1:0]    n_os_head;
    logic [15:0]      n_lv_total;
    logic [31:0]      n_lv_accum;
    logic [HW-1:0]    n_lv_head;
    logic             n_open;
    logic [7:0]       n_conf;
    logic [7:0]       n_rel;
    logic             os_we;
    logic             lv_push;
    logic             lv_close;
    logic [OS_AW-1:0] os_waddr;
    logic [LV_AW-1:0] lv_waddr;
    result_t          res;
    result_t          out_res_reg;
    logic             out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Sequencer: take an item, then execute it once the result register is free
    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign commit = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read address: newest row for a sample, selected slot for a read
    assign q_oi   = OS_IW'(q_item.ev);
    assign q_li   = LV_IW'(q_item.ev);
    assign r_head = (q_item.kind == KIND_TRIGGER || q_item.kind == KIND_READ_ONESHOT)
                    ? os_head_reg[q_oi] : lv_head_reg[q_li];
    assign r_slot = (q_item.kind == KIND_SAMPLE || !q_item.slot_ok)
                    ? '0 : q_item.slot[HW-1:0];
    assign r_sum  = {1'b0, r_head} + ((HW+1)'(HISTORY_DEPTH) - {1'b0, r_slot});
    assign r_pos  = (r_sum >= (HW+1)'(HISTORY_DEPTH))
                    ? HW'(r_sum - (HW+1)'(HISTORY_DEPTH)) : r_sum[HW-1:0];
    assign os_raddr = OS_AW'(int'(q_oi) * HISTORY_DEPTH + int'(r_pos));
    assign lv_raddr = LV_AW'(int'(q_li) * HISTORY_DEPTH + int'(r_pos));

    // Execute: one event's update and its result
    assign oi = OS_IW'(item_reg.ev);
    assign li = LV_IW'(item_reg.ev);
    assign hc = hold[item_reg.ev[1:0]];
    assign cc = confirm_reg[li];
    assign rc = release_reg[li];
    assign next_pos = (head_cap_reg == HW'(HISTORY_DEPTH - 1)) ? '0 : head_cap_reg + 1'b1;
    assign start_s  = lv_rvalid_reg ? lv_start_rdata_reg : '0;
    assign end_s    = lv_rvalid_reg ? lv_end_rdata_reg : '0;
    assign diff     = {1'b0, item_reg.now} - {1'b0, start_s[31:0]};
    assign dur      = (start_s[32] && item_reg.nv && !diff[32] && (diff[31:0] != '0))
                      ? diff[31:0] : '0;
    assign acc_sum  = {1'b0, lv_accum_reg[li]} + {1'b0, dur};
    assign conf_sum = {1'b0, cc} + {1'b0, hc};

    always_comb
    begin
        n_os_total = os_total_reg[oi];
        n_os_head  = head_cap_reg;
        n_lv_total = lv_total_reg[li];
        n_lv_accum = lv_accum_reg[li];
        n_lv_head  = head_cap_reg;
        n_open     = open_reg[li];
        n_conf     = cc;
        n_rel      = rc;
        os_we      = 1'b0;
        lv_push    = 1'b0;
        lv_close   = 1'b0;
        res        = '0;
        case (item_reg.kind)
            KIND_TRIGGER:
            begin
                if (os_total_reg[oi] != CNT_MAX)
                    n_os_total = os_total_reg[oi] + 16'd1;
                n_os_head       = next_pos;
                os_we           = 1'b1;
                res.event_total = n_os_total;
                res.start_stamp = item_reg.now;
            end
            KIND_SAMPLE:
            begin
                if (item_reg.act)
                begin
                    n_rel = '0;
                    if (cc < hc)
                        n_conf = cc + 8'd1;
                    else
                    begin
                        n_conf = conf_sum[8] ? CONFIRM_MAX : conf_sum[7:0];
                        if (!open_reg[li])
                        begin
                            lv_push = 1'b1;
                            n_open  = 1'b1;
                            if (lv_total_reg[li] != CNT_MAX)
                                n_lv_total = lv_total_reg[li] + 16'd1;
                            n_lv_head = next_pos;
                        end
                    end
                end
                else if (cc > hc)
                begin
                    if (rc < hc)
                        n_rel = rc + 8'd1;
                    else
                    begin
                        n_rel  = '0;
                        n_conf = '0;
                        if (open_reg[li])
                        begin
                            lv_close   = 1'b1;
                            n_open     = 1'b0;
                            n_lv_accum = acc_sum[32] ? ACC_MAX : acc_sum[31:0];
                        end
                    end
                end
                else
                begin
                    n_rel  = '0;
                    n_conf = '0;
                end
                res.started       = lv_push;
                res.ended         = lv_close;
                res.event_total   = n_lv_total;
                res.accum_seconds = n_lv_accum;
                res.start_stamp   = lv_push ? item_reg.now : start_s[31:0];
                res.end_stamp     = lv_push ? '0 : (lv_close ? item_reg.now : end_s[31:0]);
                res.event_open    = n_open;
            end
            KIND_READ_LEVEL:
            begin
                res.event_total   = lv_total_reg[li];
                res.accum_seconds = lv_accum_reg[li];
                res.event_open    = open_reg[li];
                if (item_reg.slot_ok)
                begin
                    res.start_stamp = start_s[31:0];
                    res.end_stamp   = end_s[31:0];
                end
            end
            KIND_READ_ONESHOT:
            begin
                res.event_total = os_total_reg[oi];
                if (item_reg.slot_ok && os_rvalid_reg)
                    res.start_stamp = os_rdata_reg;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    assign os_waddr = OS_AW'(int'(oi) * HISTORY_DEPTH + int'(n_os_head));
    assign lv_waddr = LV_AW'(int'(li) * HISTORY_DEPTH + int'(n_lv_head));

    // Control and per-event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            os_valid_reg  <= '0;
            lv_valid_reg  <= '0;
            for (int i = 0; i < ONESHOT_EVENTS; i++)
            begin
                os_total_reg[i] <= '0;
                os_head_reg[i]  <= '0;
            end
            for (int i = 0; i < LEVEL_EVENTS; i++)
            begin
                lv_total_reg[i] <= '0;
                lv_accum_reg[i] <= '0;
                lv_head_reg[i]  <= '0;
                open_reg[i]     <= 1'b0;
                confirm_reg[i]  <= '0;
                release_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (commit && item_reg.kind == KIND_TRIGGER)
            begin
                os_total_reg[oi]       <= n_os_total;
                os_head_reg[oi]        <= n_os_head;
                os_valid_reg[os_waddr] <= 1'b1;
            end
            if (commit && item_reg.kind == KIND_SAMPLE)
            begin
                lv_total_reg[li] <= n_lv_total;
                lv_accum_reg[li] <= n_lv_accum;
                lv_head_reg[li]  <= n_lv_head;
                open_reg[li]     <= n_open;
                confirm_reg[li]  <= n_conf;
                release_reg[li]  <= n_rel;
                if (lv_push)
                    lv_valid_reg[lv_waddr] <= 1'b1;
            end
        end
    end

    // Capture the item, its head and the read data; write the history memories and the result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg           <= q_item;
            head_cap_reg       <= r_head;
            os_rdata_reg       <= os_mem[os_raddr];
            os_rvalid_reg      <= os_valid_reg[os_raddr];
            lv_start_rdata_reg <= lv_start_mem[lv_raddr];
            lv_end_rdata_reg   <= lv_end_mem[lv_raddr];
            lv_rvalid_reg      <= lv_valid_reg[lv_raddr];
        end
        if (commit && os_we)
            os_mem[os_waddr] <= item_reg.now;
        if (commit && lv_push)
        begin
            lv_start_mem[lv_waddr] <= {item_reg.nv, item_reg.now};
            lv_end_mem[lv_waddr]   <= '0;
        end
        if (commit && lv_close)
            lv_end_mem[lv_waddr] <= {item_reg.nv, item_reg.now};
        if (commit)
            out_res_reg <= res;
    end

endmodule

// ----- design/debounced_event_recorder_top.sv -----
// Top level of the debounced event recorder: register port and part wiring.
//
// Usage: items enter on the in channel (in_valid / in_stall) with an opcode:
// trigger a one-shot event, sample a level event, or read a history record.
// Each item gives exactly one result on the out channel (out_valid /
// out_stall), in order. Hold counts are written over the APB-style port at
// byte addresses 0, 4, 8 and 12 while the block is idle.
// The back part reads its history memory as it takes an item and updates it
// when it commits that item's result, and it takes no new item before then.
// A two-entry queue lets up to two further items be taken while the back part
// is busy or stalled.
// Reset: counts, durations, heads, open flags and debounce counters clear,
// hold counts return to 3, and all history records read as zero until written.
// When the receiver stalls, the result register holds, the back part waits
// with its item, the queue fills and then in_stall rises.
module debounced_event_recorder_top #(
    parameter int ONESHOT_EVENTS = der_pkg::ONESHOT_EVENTS_DEF,
    parameter int LEVEL_EVENTS   = der_pkg::LEVEL_EVENTS_DEF,
    parameter int HISTORY_DEPTH  = der_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [2:0]                  event_index,
    input  logic                        level_active,
    input  logic [31:0]                 now_seconds,
    input  logic                        now_valid,
    input  logic [3:0]                  history_slot,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        started,
    output logic                        ended,
    output logic [15:0]                 event_total,
    output logic [31:0]                 accum_seconds,
    output logic [31:0]                 start_stamp,
    output logic [31:0]                 end_stamp,
    output logic                        event_open,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [der_pkg::PADDR_W-1:0] paddr,
    input  logic [der_pkg::PDATA_W-1:0] pwdata,
    output logic [der_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import der_pkg::*;

    hold_set_t hold_reg;
    logic      cfg_write;
    logic [1:0] reg_index;
    item_t     f_item;
    item_t     q_item;
    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    logic      q_full;
    result_t   res;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HOLD_REGS; i++)
                hold_reg[i] <= HOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_HOLD_A: hold_reg[0] <= pwdata[7:0];
                REG_HOLD_B: hold_reg[1] <= pwdata[7:0];
                REG_HOLD_C: hold_reg[2] <= pwdata[7:0];
                REG_HOLD_D: hold_reg[3] <= pwdata[7:0];
                default:    hold_reg    <= hold_reg;
            endcase
        end
    end

    assign prdata = {{(PDATA_W-8){1'b0}}, hold_reg[reg_index]};

    der_front #(
        .ONESHOT_EVENTS (ONESHOT_EVENTS),
        .LEVEL_EVENTS   (LEVEL_EVENTS),
        .HISTORY_DEPTH  (HISTORY_DEPTH)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .event_index  (event_index),
        .level_active (level_active),
        .now_seconds  (now_seconds),
        .now_valid    (now_valid),
        .history_slot (history_slot),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (f_item)
    );

    der_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (f_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    der_back #(
        .ONESHOT_EVENTS (ONESHOT_EVENTS),
        .LEVEL_EVENTS   (LEVEL_EVENTS),
        .HISTORY_DEPTH  (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (hold_reg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    // Result fields
    assign started       = res.started;
    assign ended         = res.ended;
    assign event_total   = res.event_total;
    assign accum_seconds = res.accum_seconds;
    assign start_stamp   = res.start_stamp;
    assign end_stamp     = res.end_stamp;
    assign event_open    = res.event_open;

endmodule

// ----- dv/debounced_event_recorder_check.sv -----
// Checker of the debounced event recorder: predicts each result and compares it.
`timescale 1ns / 1ps

module debounced_event_recorder_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [2:0]                  event_index,
    input  logic                        level_active,
    input  logic [31:0]                 now_seconds,
    input  logic                        now_valid,
    input  logic [3:0]                  history_slot,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        started,
    input  logic                        ended,
    input  logic [15:0]                 event_total,
    input  logic [31:0]                 accum_seconds,
    input  logic [31:0]                 start_stamp,
    input  logic [31:0]                 end_stamp,
    input  logic                        event_open,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [der_pkg::PADDR_W-1:0] paddr,
    input  logic [der_pkg::PDATA_W-1:0] pwdata,
    output int                          fail_count,
    output int                          outstanding
);
    import der_pkg::*;

    localparam int N_ONESHOT = ONESHOT_EVENTS_DEF;
    localparam int N_LEVEL   = LEVEL_EVENTS_DEF;
    localparam int DEPTH     = HISTORY_DEPTH_DEF;

    // Shadow of the recorder state
    logic [7:0]  hold_reg [HOLD_REGS];
    logic [15:0] os_total [N_ONESHOT];
    logic [31:0] os_hist  [N_ONESHOT][DEPTH];
    int          os_head  [N_ONESHOT];
    logic [15:0] lv_total [N_LEVEL];
    logic [31:0] lv_accum [N_LEVEL];
    logic [32:0] lv_start [N_LEVEL][DEPTH];
    logic [32:0] lv_end   [N_LEVEL][DEPTH];
    int          lv_head  [N_LEVEL];
    logic        lv_open  [N_LEVEL];
    logic [7:0]  confirm  [N_LEVEL];
    logic [7:0]  rel_cnt  [N_LEVEL];

    result_t record_expect_q [$];

    // Return everything to its state after reset
    task automatic clear_recorder();
        for (int i = 0; i < HOLD_REGS; i++)
        begin
            hold_reg[i] = HOLD_RESET;
        end
        for (int i = 0; i < N_ONESHOT; i++)
        begin
            os_total[i] = '0;
            os_head[i]  = 0;
            for (int j = 0; j < DEPTH; j++)
            begin
                os_hist[i][j] = '0;
            end
        end
        for (int i = 0; i < N_LEVEL; i++)
        begin
            lv_total[i] = '0;
            lv_accum[i] = '0;
            lv_head[i]  = 0;
            lv_open[i]  = 1'b0;
            confirm[i]  = '0;
            rel_cnt[i]  = '0;
            for (int j = 0; j < DEPTH; j++)
            begin
                lv_start[i][j] = '0;
                lv_end[i][j]   = '0;
            end
        end
    endtask

    // Apply one item to the shadow state and work out its result
    task automatic advance_recorder(
        input  logic [1:0]  op,
        input  logic [2:0]  ev,
        input  logic        act,
        input  logic [31:0] now,
        input  logic        nv,
        input  logic [3:0]  slot,
        output result_t     r
    );
        int          h;
        int          p;
        logic [7:0]  hc;
        logic [8:0]  sum;
        logic [32:0] s;
        logic [31:0] dur;
        r = '0;
        if (op == OP_TRIGGER && ev < N_ONESHOT)
        begin
            h = (os_head[ev] + 1) % DEPTH;
            if (os_total[ev] != CNT_MAX)
                os_total[ev] = os_total[ev] + 16'd1;
            os_head[ev]    = h;
            os_hist[ev][h] = now;
            r.event_total  = os_total[ev];
            r.start_stamp  = now;
        end
        else if (op == OP_SAMPLE && ev < N_LEVEL)
        begin
            hc = hold_reg[ev[1:0]];
            h  = lv_head[ev];
            if (act)
            begin
                rel_cnt[ev] = '0;
                if (confirm[ev] < hc)
                begin
                    confirm[ev] = confirm[ev] + 8'd1;
                end
                else
                begin
                    sum = {1'b0, confirm[ev]} + {1'b0, hc};
                    confirm[ev] = sum[8] ? CONFIRM_MAX : sum[7:0];
                    // confirmed start of a closed event opens a new record
                    if (!lv_open[ev])
                    begin
                        lv_open[ev] = 1'b1;
                        if (lv_total[ev] != CNT_MAX)
                            lv_total[ev] = lv_total[ev] + 16'd1;
                        h = (h + 1) % DEPTH;
                        lv_head[ev]     = h;
                        lv_start[ev][h] = {nv, now};
                        lv_end[ev][h]   = '0;
                        r.started       = 1'b1;
                    end
                end
            end
            else if (confirm[ev] > hc)
            begin
                if (rel_cnt[ev] < hc)
                begin
                    rel_cnt[ev] = rel_cnt[ev] + 8'd1;
                end
                else
                begin
                    rel_cnt[ev] = '0;
                    confirm[ev] = '0;
                    // confirmed end closes the newest record and adds its duration
                    if (lv_open[ev])
                    begin
                        s = lv_start[ev][h];
                        lv_open[ev]   = 1'b0;
                        lv_end[ev][h] = {nv, now};
                        dur = '0;
                        if (s[32] && nv && now > s[31:0])
                            dur = now - s[31:0];
                        if (dur > ACC_MAX - lv_accum[ev])
                            lv_accum[ev] = ACC_MAX;
                        else
                            lv_accum[ev] = lv_accum[ev] + dur;
                        r.ended = 1'b1;
                    end
                end
            end
            else
            begin
                rel_cnt[ev] = '0;
                confirm[ev] = '0;
            end
            r.event_total   = lv_total[ev];
            r.accum_seconds = lv_accum[ev];
            r.start_stamp   = lv_start[ev][h][31:0];
            r.end_stamp     = lv_end[ev][h][31:0];
            r.event_open    = lv_open[ev];
        end
        else if (op == OP_READ)
        begin
            if (act && ev < N_LEVEL)
            begin
                r.event_total   = lv_total[ev];
                r.accum_seconds = lv_accum[ev];
                r.event_open    = lv_open[ev];
                if (slot < DEPTH)
                begin
                    p = (lv_head[ev] + DEPTH - slot) % DEPTH;
                    r.start_stamp = lv_start[ev][p][31:0];
                    r.end_stamp   = lv_end[ev][p][31:0];
                end
            end
            else if (!act && ev < N_ONESHOT)
            begin
                r.event_total = os_total[ev];
                if (slot < DEPTH)
                begin
                    p = (os_head[ev] + DEPTH - slot) % DEPTH;
                    r.start_stamp = os_hist[ev][p];
                end
            end
        end
    endtask

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        result_t pred;
        int      bad;
        if (!rst_n)
        begin
            clear_recorder();
            record_expect_q.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // compare a taken result with the oldest expectation
            if (out_valid && !out_stall)
            begin
                got.started       = started;
                got.ended         = ended;
                got.event_total   = event_total;
                got.accum_seconds = accum_seconds;
                got.start_stamp   = start_stamp;
                got.end_stamp     = end_stamp;
                got.event_open    = event_open;
                if (record_expect_q.size() == 0)
                begin
                    $display("%0t unexpected result expected none actual %h", $time, got);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = record_expect_q.pop_front();
                    bad  = 0;
                    bad += field_mismatch("started", 32'(want.started), 32'(got.started));
                    bad += field_mismatch("ended", 32'(want.ended), 32'(got.ended));
                    bad += field_mismatch("event_total", 32'(want.event_total),
                                          32'(got.event_total));
                    bad += field_mismatch("accum_seconds", want.accum_seconds,
                                          got.accum_seconds);
                    bad += field_mismatch("start_stamp", want.start_stamp, got.start_stamp);
                    bad += field_mismatch("end_stamp", want.end_stamp, got.end_stamp);
                    bad += field_mismatch("event_open", 32'(want.event_open),
                                          32'(got.event_open));
                    fail_count = fail_count + bad;
                end
            end
            // track hold count writes
            if (psel && penable && pwrite && pready)
                hold_reg[paddr[der_pkg::PADDR_W-1:2]] = pwdata[7:0];
            // predict each taken item
            if (in_valid && !in_stall)
            begin
                advance_recorder(opcode, event_index, level_active, now_seconds, now_valid,
                                 history_slot, pred);
                record_expect_q.push_back(pred);
            end
            outstanding <= record_expect_q.size();
        end
    end

endmodule

// ----- dv/debounced_event_recorder_top_test.sv -----
// Testbench top of the debounced event recorder: stimulus, receiver pattern and verdict.
`timescale 1ns / 1ps

module debounced_event_recorder_top_test;
    import der_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int HOLD_OFF_CYCLES  = 200;
    localparam int DRAIN_LIMIT      = 20000;

    typedef enum int {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_TOGGLE,
        FLOW_HEAVY
    } flow_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [1:0]           opcode       = '0;
    logic [2:0]           event_index  = '0;
    logic                 level_active = 1'b0;
    logic [31:0]          now_seconds  = '0;
    logic                 now_valid    = 1'b0;
    logic [3:0]           history_slot = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic                 started;
    logic                 ended;
    logic [15:0]          event_total;
    logic [31:0]          accum_seconds;
    logic [31:0]          start_stamp;
    logic [31:0]          end_stamp;
    logic                 event_open;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [PADDR_W-1:0]   paddr        = '0;
    logic [PDATA_W-1:0]   pwdata       = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   outstanding;

    // Stimulus shaping state
    logic [7:0]  hold_now [HOLD_REGS];
    logic [31:0] clock_now   = '0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_off_go = 1'b0;
    int          counted     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    debounced_event_recorder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .event_index  (event_index),
        .level_active (level_active),
        .now_seconds  (now_seconds),
        .now_valid    (now_valid),
        .history_slot (history_slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .started      (started),
        .ended        (ended),
        .event_total  (event_total),
        .accum_seconds(accum_seconds),
        .start_stamp  (start_stamp),
        .end_stamp    (end_stamp),
        .event_open   (event_open),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    debounced_event_recorder_check record_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .event_index  (event_index),
        .level_active (level_active),
        .now_seconds  (now_seconds),
        .now_valid    (now_valid),
        .history_slot (history_slot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .started      (started),
        .ended        (ended),
        .event_total  (event_total),
        .accum_seconds(accum_seconds),
        .start_stamp  (start_stamp),
        .end_stamp    (end_stamp),
        .event_open   (event_open),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Offer one item, hold it until taken, then maybe idle for a while
    task automatic push_item(input logic [1:0] op, input logic [2:0] ev, input logic act,
                             input logic [31:0] now, input logic nv, input logic [3:0] slot);
        in_valid     <= 1'b1;
        opcode       <= op;
        event_index  <= ev;
        level_active <= act;
        now_seconds  <= now;
        now_valid    <= nv;
        history_slot <= slot;
        do
            @(posedge clk);
        while (in_stall);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 30);
            end
            else
            begin
                burst_left = burst_left - 1;
            end
        end
    endtask

    // Stop offering and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one hold count, then leave the port idle
    task automatic write_hold(input logic [1:0] idx, input logic [7:0] val);
        logic [31:0] junk;
        junk     = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hold_now[idx] = val;
        @(posedge clk);
    endtask

    task automatic set_holds(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d);
        settle();
        write_hold(REG_HOLD_A, a);
        write_hold(REG_HOLD_B, b);
        write_hold(REG_HOLD_C, c);
        write_hold(REG_HOLD_D, d);
    endtask

    // Advance the seconds count, with a rare jump anywhere
    task automatic tick_clock();
        if ($urandom_range(0, 39) == 0)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, 3);
    endtask

    task automatic sample(input int ev, input logic act);
        logic [3:0] slot;
        slot = 4'($urandom_range(0, 15));
        tick_clock();
        push_item(OP_SAMPLE, 3'(ev), act, clock_now, $urandom_range(0, 9) != 0, slot);
        counted = counted + 1;
    endtask

    // A run of asserted samples followed by released ones, sometimes cut short
    task automatic episode(input int ev);
        int h;
        int na;
        int nr;
        h = hold_now[ev];
        if (h <= 12)
        begin
            na = h + 1 + $urandom_range(0, 2);
            nr = h + 1 + $urandom_range(0, 2);
        end
        else
        begin
            na = $urandom_range(1, 4);
            nr = $urandom_range(1, 4);
        end
        if ($urandom_range(0, 6) == 0)
            na = $urandom_range(0, na);
        if ($urandom_range(0, 6) == 0)
            nr = $urandom_range(0, nr);
        repeat (na) sample(ev, 1'b1);
        repeat (nr) sample(ev, 1'b0);
    endtask

    // Mixed random traffic until the phase has its share of items
    task automatic random_phase(input int n);
        int          pick;
        logic [2:0]  ev;
        logic        act;
        logic [3:0]  slot;
        logic [31:0] noise;
        counted = 0;
        while (counted < n)
        begin
            pick = $urandom_range(0, 99);
            ev   = 3'($urandom_range(0, 7));
            act  = 1'($urandom_range(0, 1));
            slot = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            if (pick < 45)
            begin
                episode($urandom_range(0, 3));
            end
            else if (pick < 60)
            begin
                tick_clock();
                push_item(OP_TRIGGER, ev, act, clock_now, act, slot);
                counted = counted + 1;
            end
            else if (pick < 82)
            begin
                if (act && $urandom_range(0, 3) != 0)
                    ev[2] = 1'b0;
                push_item(OP_READ, ev, act, $urandom, 1'($urandom_range(0, 1)), slot);
                counted = counted + 1;
            end
            else if (pick < 92)
            begin
                sample($urandom_range(0, 3), act);
            end
            else
            begin
                // ignored items: spare opcode or a level event out of range
                noise = $urandom;
                if (pick < 96)
                    push_item(OP_SPARE, ev, act, noise, noise[0], slot);
                else
                    push_item(OP_SAMPLE, {1'b1, ev[1:0]}, act, noise, noise[1], slot);
            end
        end
    endtask

    // Receiver: stall on changing patterns, with one long hold-off on request
    initial
    begin : receiver
        flow_t mode;
        int    seg;
        forever
        begin
            mode = flow_t'($urandom_range(0, 3));
            seg  = $urandom_range(10, 80);
            repeat (seg)
            begin
                @(posedge clk);
                if (hold_off_go)
                begin
                    hold_off_go = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (mode)
                    FLOW_FREE:   out_stall <= 1'b0;
                    FLOW_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    FLOW_TOGGLE: out_stall <= ~out_stall;
                    default:     out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int waited;
        for (int i = 0; i < HOLD_REGS; i++)
        begin
            hold_now[i] = HOLD_RESET;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, extremes, ignored items
        push_item(OP_READ, 3'd0, 1'b1, '0, 1'b0, 4'd0);
        push_item(OP_READ, 3'd7, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'd9);
        push_item(OP_TRIGGER, 3'd0, 1'b0, '0, 1'b1, 4'd0);
        push_item(OP_TRIGGER, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b0, 4'd15);
        push_item(OP_READ, 3'd7, 1'b0, '0, 1'b0, 4'd0);
        push_item(OP_READ, 3'd7, 1'b0, '0, 1'b0, 4'd15);
        push_item(OP_SPARE, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'd15);
        push_item(OP_SAMPLE, 3'd4, 1'b1, 32'h0000_0100, 1'b1, 4'd0);
        push_item(OP_READ, 3'd5, 1'b1, '0, 1'b1, 4'd0);
        // two long episodes on event 0 drive its total duration into saturation
        repeat (2)
        begin
            repeat (4) push_item(OP_SAMPLE, 3'd0, 1'b1, '0, 1'b1, 4'd0);
            repeat (4) push_item(OP_SAMPLE, 3'd0, 1'b0, 32'hFFFF_FFF0, 1'b1, 4'd0);
        end
        push_item(OP_READ, 3'd0, 1'b1, '0, 1'b0, 4'd1);

        // Reset hold counts; back-to-back offers against a long receiver hold-off
        gaps_on     = 1'b0;
        hold_off_go = 1'b1;
        random_phase(40);
        gaps_on = 1'b1;
        random_phase(80);

        // Zero and full hold counts; one run long enough to confirm at 255
        set_holds(8'd0, 8'd1, 8'd2, 8'd255);
        counted = 0;
        repeat (257) sample(3, 1'b1);
        repeat (3) sample(3, 1'b0);
        random_phase(60);

        set_holds(8'd255, 8'd255, 8'd255, 8'd0);
        random_phase(40);

        set_holds(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
        random_phase(160);

        // Drain and give the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited = waited + 1;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Give up after a generous time
    initial
    begin : watchdog
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- debounced_event_recorder_top.f -----
design/der_pkg.sv
design/der_front.sv
design/der_queue.sv
design/der_back.sv
design/debounced_event_recorder_top.sv
dv/debounced_event_recorder_check.sv
dv/debounced_event_recorder_top_test.sv
